// ===== design/xpd_pkg.sv =====
`default_nettype none

package xpd_pkg;

	localparam logic [7:0] BYTE_LOCK  = 8'hF0;
	localparam logic [7:0] BYTE_REPNZ = 8'hF2;
	localparam logic [7:0] BYTE_REPZ  = 8'hF3;
	localparam logic [7:0] BYTE_CS    = 8'h2E;
	localparam logic [7:0] BYTE_SS    = 8'h36;
	localparam logic [7:0] BYTE_DS    = 8'h3E;
	localparam logic [7:0] BYTE_ES    = 8'h26;
	localparam logic [7:0] BYTE_FS    = 8'h64;
	localparam logic [7:0] BYTE_GS    = 8'h65;
	localparam logic [7:0] BYTE_OPSZ  = 8'h66;
	localparam logic [7:0] BYTE_ADSZ  = 8'h67;
	localparam logic [7:0] BYTE_REX_LO = 8'h40;
	localparam logic [7:0] BYTE_REX_HI = 8'h4F;
	localparam logic [7:0] BYTE_VEX2  = 8'hC5;
	localparam logic [7:0] BYTE_VEX3  = 8'hC4;
	localparam logic [7:0] BYTE_EVEX  = 8'h62;

	localparam logic [1:0] LR_NONE  = 2'd0;
	localparam logic [1:0] LR_LOCK  = 2'd1;
	localparam logic [1:0] LR_REPNZ = 2'd2;
	localparam logic [1:0] LR_REPZ  = 2'd3;

	localparam logic [2:0] SEG_CS = 3'd1;
	localparam logic [2:0] SEG_SS = 3'd2;
	localparam logic [2:0] SEG_DS = 3'd3;
	localparam logic [2:0] SEG_ES = 3'd4;
	localparam logic [2:0] SEG_FS = 3'd5;
	localparam logic [2:0] SEG_GS = 3'd6;

	localparam logic [1:0] VF_NONE = 2'd0;
	localparam logic [1:0] VF_VEX2 = 2'd1;
	localparam logic [1:0] VF_VEX3 = 2'd2;
	localparam logic [1:0] VF_EVEX = 2'd3;

	localparam logic [1:0] PP_66 = 2'd1;
	localparam logic [1:0] PP_F3 = 2'd2;
	localparam logic [1:0] PP_F2 = 2'd3;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_TRUNC = 1'b1;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       buffer_end;
	} code_beat_t;

	typedef struct packed {
		logic       status;
		logic [7:0] opcode_byte;
		logic [1:0] lock_rep_group;
		logic [2:0] segment_group;
		logic [2:0] misc_flags;
		logic [4:0] rex_bits;
		logic [1:0] vector_form;
		logic [4:0] vector_rxbw;
		logic [4:0] map_select;
		logic [4:0] source_register;
		logic [3:0] length_and_pp;
		logic [4:0] evex_mask_bits;
	} result_beat_t;

endpackage

`default_nettype wire

// ===== design/x86_prefix_decoder.sv =====
// Prefix decoder for an x86-64 instruction byte stream.
// The byte channel (byte_valid, byte_stall, byte_data) takes one code byte per
// beat, with buffer_end set on the last byte the fetch buffer holds.
// Legacy prefixes, an optional REX byte or a VEX/EVEX prefix are absorbed, and
// the first opcode byte produces one beat on the result channel (result_valid,
// result_stall, result_data) carrying all decoded fields. A buffer that ends
// inside the prefixes produces a result with status set and all else zero.
// Each byte is captured in an input register and then decoded into the result
// register, which holds a result until the result channel takes it.
// One byte is accepted per cycle at sustained rate while the result channel
// does not stall; the single decode stage with its held prefix state sets that
// figure. While the result channel stalls with a result pending, the input
// register still takes one more byte; byte_stall rises after that.
// Reset clears the valid flags of the input and result registers and the prefix
// state, so no result is pending and the decoder expects a new instruction.
`default_nettype none

module x86_prefix_decoder
	import xpd_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           byte_valid,
	output logic          byte_stall,
	input  code_beat_t    byte_data,
	output logic          result_valid,
	input  wire           result_stall,
	output result_beat_t  result_data
);

	typedef enum logic [2:0] {
		PH_LEGACY, PH_OPCODE, PH_V2, PH_V3A, PH_V3B, PH_E0, PH_E1, PH_E2
	} phase_t;

	logic         valid_s1;
	code_beat_t   beat_s1;

	phase_t       phase_q;
	logic [1:0]   lock_rep_q;
	logic [2:0]   segment_q;
	logic [1:0]   size_q;
	logic [4:0]   rex_q;
	logic [1:0]   vform_q;
	logic [23:0]  payload_q;

	logic         result_valid_q;
	result_beat_t result_q;

	logic         go;
	logic         emit;
	logic         trunc;
	phase_t       phase_d;
	logic [1:0]   lock_rep_d;
	logic [2:0]   segment_d;
	logic [1:0]   size_d;
	logic [4:0]   rex_d;
	logic [1:0]   vform_d;
	logic [23:0]  payload_d;
	result_beat_t emit_res;
	result_beat_t trunc_res;

	assign go         = valid_s1 && !(result_valid_q && result_stall);
	assign byte_stall = valid_s1 && !go;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1 <= byte_data;
		end
	end

	// Next prefix state and the decision whether this byte ends the run.
	always_comb begin
		phase_d    = phase_q;
		lock_rep_d = lock_rep_q;
		segment_d  = segment_q;
		size_d     = size_q;
		rex_d      = rex_q;
		vform_d    = vform_q;
		payload_d  = payload_q;
		emit       = 1'b0;
		unique case (phase_q)
			PH_LEGACY: begin
				case (beat_s1.code_byte) inside
					BYTE_LOCK:  lock_rep_d = LR_LOCK;
					BYTE_REPNZ: lock_rep_d = LR_REPNZ;
					BYTE_REPZ:  lock_rep_d = LR_REPZ;
					BYTE_CS:    segment_d = SEG_CS;
					BYTE_SS:    segment_d = SEG_SS;
					BYTE_DS:    segment_d = SEG_DS;
					BYTE_ES:    segment_d = SEG_ES;
					BYTE_FS:    segment_d = SEG_FS;
					BYTE_GS:    segment_d = SEG_GS;
					BYTE_OPSZ:  size_d = size_q | 2'b01;
					BYTE_ADSZ:  size_d = size_q | 2'b10;
					BYTE_VEX2: begin
						vform_d = VF_VEX2;
						phase_d = PH_V2;
					end
					BYTE_VEX3: begin
						vform_d = VF_VEX3;
						phase_d = PH_V3A;
					end
					BYTE_EVEX: begin
						vform_d = VF_EVEX;
						phase_d = PH_E0;
					end
					[BYTE_REX_LO:BYTE_REX_HI]: begin
						rex_d   = {1'b1, beat_s1.code_byte[3:0]};
						phase_d = PH_OPCODE;
					end
					default: emit = 1'b1;
				endcase
			end
			PH_OPCODE: emit = 1'b1;
			PH_V2, PH_V3B, PH_E2: begin
				payload_d = {payload_q[15:0], beat_s1.code_byte};
				phase_d   = PH_OPCODE;
			end
			PH_V3A: begin
				payload_d = {payload_q[15:0], beat_s1.code_byte};
				phase_d   = PH_V3B;
			end
			PH_E0: begin
				payload_d = {payload_q[15:0], beat_s1.code_byte};
				phase_d   = PH_E1;
			end
			PH_E1: begin
				payload_d = {payload_q[15:0], beat_s1.code_byte};
				phase_d   = PH_E2;
			end
		endcase
		trunc = !emit && beat_s1.buffer_end;
	end

	// Result fields built from the held prefix state.
	always_comb begin
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       r;
		logic       x;
		logic       bb;
		logic       w;
		logic       rp;
		logic [4:0] map;
		logic [4:0] vv;
		logic [1:0] len;
		logic [1:0] pp;
		logic [4:0] mask;
		logic [1:0] lr;
		logic [1:0] flags;
		logic       baseext;
		b0    = payload_q[23:16];
		b1    = payload_q[15:8];
		b2    = payload_q[7:0];
		r     = 1'b0;
		x     = 1'b0;
		bb    = 1'b0;
		w     = 1'b0;
		rp    = 1'b0;
		map   = 5'd0;
		vv    = 5'd0;
		len   = 2'd0;
		pp    = 2'd0;
		mask  = 5'd0;
		lr    = lock_rep_q;
		flags = size_q;
		unique case (vform_q)
			VF_NONE: begin
			end
			VF_VEX2: begin
				r   = b2[7];
				x   = 1'b1;
				bb  = 1'b1;
				map = 5'd1;
				vv  = {1'b0, b2[6:3]};
				len = {1'b0, b2[2]};
				pp  = b2[1:0];
			end
			VF_VEX3: begin
				r   = b1[7];
				x   = b1[6];
				bb  = b1[5];
				map = b1[4:0];
				w   = b2[7];
				vv  = {1'b0, b2[6:3]};
				len = {1'b0, b2[2]};
				pp  = b2[1:0];
			end
			VF_EVEX: begin
				r    = b0[7];
				x    = b0[6];
				bb   = b0[5];
				rp   = b0[4];
				map  = {2'b00, b0[2:0]};
				w    = b1[7];
				vv   = {b2[3], b1[6:3]};
				pp   = b1[1:0];
				len  = b2[6:5];
				mask = {b2[7], b2[4], b2[2:0]};
			end
		endcase
		if (vform_q != VF_NONE) begin
			case (pp)
				PP_66:   flags = flags | 2'b01;
				PP_F3:   lr = LR_REPZ;
				PP_F2:   lr = LR_REPNZ;
				default: ;
			endcase
			baseext = !bb;
		end else begin
			baseext = rex_q[0];
		end
		emit_res.status          = STATUS_OK;
		emit_res.opcode_byte     = beat_s1.code_byte;
		emit_res.lock_rep_group  = lr;
		emit_res.segment_group   = segment_q;
		emit_res.misc_flags      = {baseext, flags};
		emit_res.rex_bits        = rex_q;
		emit_res.vector_form     = vform_q;
		emit_res.vector_rxbw     = {r, x, bb, w, rp};
		emit_res.map_select      = map;
		emit_res.source_register = vv;
		emit_res.length_and_pp   = {len, pp};
		emit_res.evex_mask_bits  = mask;
		trunc_res                = '0;
		trunc_res.status         = STATUS_TRUNC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEGACY;
			lock_rep_q <= LR_NONE;
			segment_q <= 3'd0;
			size_q    <= 2'd0;
			rex_q     <= 5'd0;
			vform_q   <= VF_NONE;
			payload_q <= 24'd0;
		end else if (go) begin
			if (emit || trunc) begin
				phase_q    <= PH_LEGACY;
				lock_rep_q <= LR_NONE;
				segment_q  <= 3'd0;
				size_q     <= 2'd0;
				rex_q      <= 5'd0;
				vform_q    <= VF_NONE;
				payload_q  <= 24'd0;
			end else begin
				phase_q    <= phase_d;
				lock_rep_q <= lock_rep_d;
				segment_q  <= segment_d;
				size_q     <= size_d;
				rex_q      <= rex_d;
				vform_q    <= vform_d;
				payload_q  <= payload_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go) begin
			result_valid_q <= emit || trunc;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (emit) begin
				result_q <= emit_res;
			end else begin
				result_q <= trunc_res;
			end
		end
	end

	a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("Input stalled with the input register empty.");

	a_rex_then_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		rex_q[4] |-> (phase_q == PH_OPCODE))
		else $error("REX held outside the opcode phase.");

	a_plain_phases: assert property (@(posedge clk) disable iff (!arst_n)
		(vform_q == VF_NONE) |-> (phase_q == PH_LEGACY || phase_q == PH_OPCODE))
		else $error("Vector payload phase without a vector prefix.");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (emit || trunc)) |=> (phase_q == PH_LEGACY && vform_q == VF_NONE
			&& rex_q == 5'd0 && result_valid_q))
		else $error("Prefix state not cleared after a result.");

endmodule

`default_nettype wire
